// File: hdl/hotplug_detect_sequencer_macros.svh
// assertion macros used by the hotplug-detect sequencer state machine
`ifndef HOTPLUG_DETECT_SEQUENCER_MACROS_SVH
`define HOTPLUG_DETECT_SEQUENCER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hpd_seq_pkg.sv
// shared types and constants of the hotplug-detect sequencer
`timescale 1ns / 1ps

package hpd_seq_pkg;

    localparam int TICK_W      = 16;
    localparam int ATTEMPT_W   = 3;
    localparam int CFG_INDEX_W = 3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_RESET    = 3'd0,
        ST_PLUG     = 3'd1,
        ST_CHECK    = 3'd2,
        ST_DISABLED = 3'd3,
        ST_ENABLED  = 3'd4,
        ST_WAIT     = 3'd5,
        ST_RECHECK  = 3'd6,
        ST_BOOT     = 3'd7
    } state_t;

    // action codes
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_EVENT    = 2'd1;
    localparam logic [1:0] ACT_SHUTDOWN = 2'd2;

    // edid recheck codes
    localparam logic [1:0] RECHECK_UNCHANGED = 2'd0;
    localparam logic [1:0] RECHECK_FAILED    = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STABILIZE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_TIMEOUT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLUG_CHECK   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDID_RETRY   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS = 3'd4;

    // register reset values
    localparam logic [TICK_W-1:0]    RST_STABILIZE    = 16'd40;
    localparam logic [TICK_W-1:0]    RST_DROP_TIMEOUT = 16'd1500;
    localparam logic [TICK_W-1:0]    RST_PLUG_CHECK   = 16'd10;
    localparam logic [TICK_W-1:0]    RST_EDID_RETRY   = 16'd60;
    localparam logic [ATTEMPT_W-1:0] RST_MAX_ATTEMPTS = 3'd5;

    localparam logic [ATTEMPT_W-1:0] ATTEMPT_SAT = 3'd7;

    typedef struct packed {
        logic [TICK_W-1:0]    stabilize_ticks;
        logic [TICK_W-1:0]    drop_timeout_ticks;
        logic [TICK_W-1:0]    plug_check_ticks;
        logic [TICK_W-1:0]    edid_retry_ticks;
        logic [ATTEMPT_W-1:0] max_edid_attempts;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        logic       hpd_level;
        logic       edid_read_ok;
        logic [1:0] recheck_status;
    } in_word_t;

    typedef struct packed {
        state_t               cur_state;
        logic                 worker_ran;
        logic                 disable_pulse;
        logic                 edid_ready_pulse;
        logic                 timer_armed;
        logic [ATTEMPT_W-1:0] attempts_used;
        logic                 shutdown_pulse;
    } out_word_t;

endpackage

// File: hdl/hpd_seq_cfg.sv
// configuration registers of the hotplug-detect sequencer
`timescale 1ns / 1ps

module hpd_seq_cfg
    import hpd_seq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]      cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stabilize_ticks    <= RST_STABILIZE;
            cfg_reg.drop_timeout_ticks <= RST_DROP_TIMEOUT;
            cfg_reg.plug_check_ticks   <= RST_PLUG_CHECK;
            cfg_reg.edid_retry_ticks   <= RST_EDID_RETRY;
            cfg_reg.max_edid_attempts  <= RST_MAX_ATTEMPTS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STABILIZE:    cfg_reg.stabilize_ticks    <= cfg_data;
                CFG_DROP_TIMEOUT: cfg_reg.drop_timeout_ticks <= cfg_data;
                CFG_PLUG_CHECK:   cfg_reg.plug_check_ticks   <= cfg_data;
                CFG_EDID_RETRY:   cfg_reg.edid_retry_ticks   <= cfg_data;
                CFG_MAX_ATTEMPTS: cfg_reg.max_edid_attempts  <= cfg_data[ATTEMPT_W-1:0];
                default:          ; // writes beyond the list are dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/hpd_seq_fsm.sv
// sequencer state, timer and single-pass step logic
`timescale 1ns / 1ps
`include "hotplug_detect_sequencer_macros.svh"

module hpd_seq_fsm
    import hpd_seq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_word_t  item,
    input  cfg_t      cfg,
    output out_word_t result
);

    state_t               state_reg,    state_next;
    logic [TICK_W-1:0]    countdown_reg, countdown_next;
    logic                 armed_reg,    armed_next;
    logic                 pending_reg,  pending_next;
    logic [ATTEMPT_W-1:0] attempts_reg, attempts_next;
    logic                 halted_reg,   halted_next;

    logic                 run;
    logic                 resched;
    logic [TICK_W-1:0]    delay;
    logic [ATTEMPT_W-1:0] fail_cnt;
    logic                 give_up;

    // saturating failure count and give-up test
    assign fail_cnt = (attempts_reg < ATTEMPT_SAT) ? attempts_reg + 3'd1 : ATTEMPT_SAT;
    assign give_up  = (fail_cnt >= cfg.max_edid_attempts);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BOOT;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            attempts_reg  <= '0;
            halted_reg    <= 1'b0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            countdown_reg <= countdown_next;
            armed_reg     <= armed_next;
            pending_reg   <= pending_next;
            attempts_reg  <= attempts_next;
            halted_reg    <= halted_next;
        end
    end

    always_comb
    begin : next_state
        state_next     = state_reg;
        countdown_next = countdown_reg;
        armed_next     = armed_reg;
        pending_next   = pending_reg;
        attempts_next  = attempts_reg;
        halted_next    = halted_reg;
        run            = 1'b0;
        resched        = 1'b0;
        delay          = '0;

        unique case (item.action)
            ACT_TICK:
            begin
                if (armed_reg)
                begin
                    if (countdown_reg <= 16'd1)
                    begin
                        run          = step;
                        armed_next   = 1'b0;
                        pending_next = 1'b0;
                        if (pending_reg)
                        begin
                            // hotplug event rules
                            priority if (state_reg == ST_ENABLED && !item.hpd_level)
                            begin
                                state_next = ST_WAIT;
                                resched    = 1'b1;
                                delay      = cfg.drop_timeout_ticks;
                            end
                            else if (state_reg == ST_WAIT && item.hpd_level)
                            begin
                                attempts_next = '0;
                                state_next    = ST_RECHECK;
                                resched       = 1'b1;
                                delay         = cfg.edid_retry_ticks;
                            end
                            else if (state_reg == ST_ENABLED && item.hpd_level)
                            begin
                                // bounce while enabled, schedule stays consumed
                            end
                            else if (state_reg == ST_BOOT && item.hpd_level)
                            begin
                                state_next = ST_PLUG;
                                resched    = 1'b1;
                                delay      = cfg.stabilize_ticks;
                            end
                            else
                            begin
                                state_next = ST_RESET;
                                resched    = 1'b1;
                                delay      = cfg.stabilize_ticks;
                            end
                        end
                        else
                        begin
                            unique case (state_reg)
                                ST_RESET:
                                begin
                                    state_next = ST_PLUG;
                                    resched    = 1'b1;
                                    delay      = cfg.plug_check_ticks;
                                end
                                ST_PLUG:
                                begin
                                    if (item.hpd_level)
                                    begin
                                        attempts_next = '0;
                                        state_next    = ST_CHECK;
                                        resched       = 1'b1;
                                        delay         = cfg.edid_retry_ticks;
                                    end
                                    else
                                    begin
                                        state_next = ST_DISABLED;
                                    end
                                end
                                ST_CHECK:
                                begin
                                    priority if (!item.hpd_level)
                                    begin
                                        state_next = ST_DISABLED;
                                    end
                                    else if (!item.edid_read_ok)
                                    begin
                                        attempts_next = fail_cnt;
                                        if (give_up)
                                        begin
                                            state_next = ST_DISABLED;
                                        end
                                        else
                                        begin
                                            state_next = ST_CHECK;
                                            resched    = 1'b1;
                                            delay      = cfg.edid_retry_ticks;
                                        end
                                    end
                                    else
                                    begin
                                        state_next = ST_ENABLED;
                                    end
                                end
                                ST_WAIT:
                                begin
                                    state_next = ST_RESET;
                                    resched    = 1'b1;
                                end
                                ST_RECHECK:
                                begin
                                    priority if (item.recheck_status == RECHECK_FAILED)
                                    begin
                                        attempts_next = fail_cnt;
                                        state_next    = give_up ? ST_RESET : ST_RECHECK;
                                        resched       = 1'b1;
                                        delay         = give_up ? '0 : cfg.edid_retry_ticks;
                                    end
                                    else if (item.recheck_status == RECHECK_UNCHANGED)
                                    begin
                                        state_next = ST_ENABLED;
                                    end
                                    else
                                    begin
                                        state_next = ST_RESET;
                                        resched    = 1'b1;
                                    end
                                end
                                ST_DISABLED, ST_ENABLED, ST_BOOT:
                                begin
                                    // steady states, nothing to do
                                end
                            endcase
                        end
                        if (resched && !halted_reg)
                        begin
                            armed_next     = 1'b1;
                            countdown_next = delay;
                        end
                    end
                    else
                    begin
                        countdown_next = countdown_reg - 16'd1;
                    end
                end
            end
            ACT_EVENT:
            begin
                pending_next = 1'b1;
                if (!halted_reg)
                begin
                    armed_next     = 1'b1;
                    countdown_next = '0;
                end
            end
            ACT_SHUTDOWN:
            begin
                halted_next = 1'b1;
                armed_next  = 1'b0;
            end
            default:
            begin
                // unused code, no change
            end
        endcase
    end

    always_comb
    begin : outputs
        result.cur_state        = state_next;
        result.worker_ran       = run;
        result.disable_pulse    = run && !pending_reg &&
                                  ((state_reg == ST_RESET) ||
                                   (state_reg == ST_PLUG && !item.hpd_level) ||
                                   (state_reg == ST_CHECK &&
                                    (!item.hpd_level || (!item.edid_read_ok && give_up))));
        result.edid_ready_pulse = run && !pending_reg && (state_reg == ST_CHECK) &&
                                  item.hpd_level && item.edid_read_ok;
        result.timer_armed      = armed_next;
        result.attempts_used    = attempts_next;
        result.shutdown_pulse   = step && (item.action == ACT_SHUTDOWN);
    end

    `HPD_ASSERT_SAME(a_halt_never_armed, halted_reg, !armed_reg,
        "timer armed after shutdown")
    `HPD_ASSERT_SAME(a_pulses_exclusive, step, !(result.disable_pulse && result.edid_ready_pulse),
        "disable and edid-ready pulsed together")
    `HPD_ASSERT_SAME(a_ready_enters_enabled, step && result.edid_ready_pulse,
        result.cur_state == ST_ENABLED, "edid-ready without entering enabled")
    `HPD_ASSERT_NEXT(a_idle_tick_holds, step && item.action == ACT_TICK && !armed_reg,
        $stable(state_reg) && $stable(countdown_reg), "unarmed tick changed state")

endmodule

// File: hdl/hotplug_detect_sequencer.sv
// top level of the hotplug-detect sequencer
`timescale 1ns / 1ps

//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------
//  in      | in        | in_valid/in_stall | in_data  (in_word_t)
//  out     | out       | out_valid/out_stall | out_data (out_word_t)
//  cfg     | in        | cfg_we            | cfg_index, cfg_data
//
//  one word per cycle while out_stall is low; a word passes through the input register
//  and then the result register before it shows on out_data
//  the step itself is a single pass of compares and one 16-bit decrement
//  reset puts the machine in bootloader takeover with the timer disarmed,
//  registers at their defaults; no clearing pass is needed
//  out_stall holds the result register; a word waits in the input register and
//  in_stall rises only when both registers are full

module hotplug_detect_sequencer
    import hpd_seq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]      cfg_data
);

    // input register
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    // result register
    logic      out_valid_reg;
    out_word_t out_word_reg;

    logic      advance;
    logic      take;
    cfg_t      cfg;
    out_word_t step_result;

    // the held word steps through the machine when the result register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= step_result;
        end
    end

    // timing and limit registers
    hpd_seq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // machine state and step logic
    hpd_seq_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_word_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

// File: verif/tb_hotplug_detect_sequencer.sv
// self-checking testbench for the hotplug-detect sequencer
`timescale 1ns / 1ps

module tb_hotplug_detect_sequencer;
    import hpd_seq_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] ACT_UNUSED      = 2'd3;
    localparam logic [1:0] RECHECK_CHANGED = 2'd1;
    localparam logic [1:0] RECHECK_UNKNOWN = 2'd3;

    // handler result that leaves the timer disarmed
    localparam int NO_REARM = -1;

    // a correct run stays well under this limit, so it is only a hang guard
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 240;
    localparam int REPORT_MAX  = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]      cfg_data = '0;

    hotplug_detect_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor: a private copy of the sequencer state and its registers
    // ------------------------------------------------------------------
    cfg_t settings = '{
        stabilize_ticks:    RST_STABILIZE,
        drop_timeout_ticks: RST_DROP_TIMEOUT,
        plug_check_ticks:   RST_PLUG_CHECK,
        edid_retry_ticks:   RST_EDID_RETRY,
        max_edid_attempts:  RST_MAX_ATTEMPTS
    };
    state_t               seq_state = ST_BOOT;
    logic [TICK_W-1:0]    tick_count = '0;
    bit                   timer_on = 1'b0;
    bit                   event_waiting = 1'b0;
    logic [ATTEMPT_W-1:0] fail_count = '0;
    bit                   halted_flag = 1'b0;
    bit                   drop_pulse;
    bit                   ready_pulse;

    out_word_t expected_words[$];

    // scoreboard and run statistics
    int        mismatches = 0;
    int        words_checked = 0;
    int        worker_runs = 0;
    int        disable_seen = 0;
    int        ready_seen = 0;
    int        settings_used = 1;
    logic [7:0] state_mask = '0;
    int        cycle_count = 0;

    // knobs for the two sides' idling
    bit sender_gaps = 1'b1;
    bit receiver_stalls = 1'b1;

    // level of the modelled hotplug line across random phases
    bit plug_line = 1'b0;

    // a schedule replaces whatever was pending; after shutdown nothing arms
    function automatic void arm_timer(int delay);
        timer_on = 1'b0;
        if (delay >= 0 && !halted_flag)
        begin
            timer_on = 1'b1;
            tick_count = delay[TICK_W-1:0];
        end
    endfunction

    function automatic void move_to(state_t target, int delay);
        seq_state = target;
        if (!event_waiting)
            arm_timer(delay);
    endfunction

    // failed edid attempts saturate rather than wrap
    function automatic void note_failure();
        if (fail_count < ATTEMPT_SAT)
            fail_count = fail_count + 1'b1;
    endfunction

    // hotplug activity overrides the state handler
    function automatic void apply_event(bit hpd);
        if (seq_state == ST_ENABLED && !hpd)
            move_to(ST_WAIT, int'(settings.drop_timeout_ticks));
        else if (seq_state == ST_WAIT && hpd)
        begin
            fail_count = '0;
            move_to(ST_RECHECK, int'(settings.edid_retry_ticks));
        end
        else if (seq_state == ST_ENABLED && hpd)
            ;   // bounce while enabled: schedule stays consumed
        else if (seq_state == ST_BOOT && hpd)
            move_to(ST_PLUG, int'(settings.stabilize_ticks));
        else
            move_to(ST_RESET, int'(settings.stabilize_ticks));
    endfunction

    function automatic void run_state(bit hpd, bit read_ok, logic [1:0] status);
        case (seq_state)
            ST_RESET:
            begin
                drop_pulse = 1'b1;
                move_to(ST_PLUG, int'(settings.plug_check_ticks));
            end
            ST_PLUG:
            begin
                if (hpd)
                begin
                    fail_count = '0;
                    move_to(ST_CHECK, int'(settings.edid_retry_ticks));
                end
                else
                begin
                    drop_pulse = 1'b1;
                    move_to(ST_DISABLED, NO_REARM);
                end
            end
            ST_CHECK:
            begin
                if (!hpd)
                begin
                    drop_pulse = 1'b1;
                    move_to(ST_DISABLED, NO_REARM);
                end
                else if (!read_ok)
                begin
                    note_failure();
                    if (fail_count >= settings.max_edid_attempts)
                    begin
                        drop_pulse = 1'b1;
                        move_to(ST_DISABLED, NO_REARM);
                    end
                    else
                        move_to(ST_CHECK, int'(settings.edid_retry_ticks));
                end
                else
                begin
                    ready_pulse = 1'b1;
                    move_to(ST_ENABLED, NO_REARM);
                end
            end
            ST_WAIT:
                move_to(ST_RESET, 0);
            ST_RECHECK:
            begin
                if (status == RECHECK_FAILED)
                begin
                    note_failure();
                    if (fail_count >= settings.max_edid_attempts)
                        move_to(ST_RESET, 0);
                    else
                        move_to(ST_RECHECK, int'(settings.edid_retry_ticks));
                end
                else if (status == RECHECK_UNCHANGED)
                    move_to(ST_ENABLED, NO_REARM);
                else
                    move_to(ST_RESET, 0);   // changed, and the unknown code with it
            end
            default:
                ;   // disabled, enabled and boot sit still without an event
        endcase
    endfunction

    // one accepted input word in, the word the sequencer must answer with out
    function automatic out_word_t sequencer_step(in_word_t w);
        out_word_t r;
        bit ran;
        bit shut;
        bit pend;
        ran = 1'b0;
        shut = 1'b0;
        drop_pulse = 1'b0;
        ready_pulse = 1'b0;
        case (w.action)
            ACT_TICK:
            begin
                if (timer_on)
                begin
                    if (tick_count <= 1)
                    begin
                        pend = event_waiting;
                        timer_on = 1'b0;
                        event_waiting = 1'b0;
                        ran = 1'b1;
                        if (pend)
                            apply_event(w.hpd_level);
                        else
                            run_state(w.hpd_level, w.edid_read_ok, w.recheck_status);
                    end
                    else
                        tick_count = tick_count - 1'b1;
                end
            end
            ACT_EVENT:
            begin
                event_waiting = 1'b1;
                arm_timer(0);
            end
            ACT_SHUTDOWN:
            begin
                halted_flag = 1'b1;
                timer_on = 1'b0;
                shut = 1'b1;
            end
            default:
                ;   // unused code: state is only reported
        endcase
        r.cur_state        = seq_state;
        r.worker_ran       = ran;
        r.disable_pulse    = drop_pulse;
        r.edid_ready_pulse = ready_pulse;
        r.timer_armed      = timer_on;
        r.attempts_used    = fail_count;
        r.shutdown_pulse   = shut;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch at word %0d: %s got %0d want %0d",
                     words_checked, what, got, want);
    endtask

    task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // outputs are sampled at the edge, before any update of that edge lands
    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("word with nothing predicted", 8'(out_data.cur_state), 8'd0);
            else
            begin
                want = expected_words.pop_front();
                check_field("cur_state", 8'(out_data.cur_state), 8'(want.cur_state));
                check_field("worker_ran", 8'(out_data.worker_ran), 8'(want.worker_ran));
                check_field("disable_pulse", 8'(out_data.disable_pulse),
                            8'(want.disable_pulse));
                check_field("edid_ready_pulse", 8'(out_data.edid_ready_pulse),
                            8'(want.edid_ready_pulse));
                check_field("timer_armed", 8'(out_data.timer_armed), 8'(want.timer_armed));
                check_field("attempts_used", 8'(out_data.attempts_used),
                            8'(want.attempts_used));
                check_field("shutdown_pulse", 8'(out_data.shutdown_pulse),
                            8'(want.shutdown_pulse));
                words_checked++;
                worker_runs += int'(want.worker_ran);
                disable_seen += int'(want.disable_pulse);
                ready_seen += int'(want.edid_ready_pulse);
                state_mask[want.cur_state] = 1'b1;
            end
        end
    end

    // receiver back-pressure, switched off for the quiet stretch
    always @(posedge clk)
        out_stall <= receiver_stalls && ($urandom_range(0, 99) < 25);

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // offer one word, hold it through stalls, predict at the accepting edge
    task automatic send_word(logic [1:0] act, bit hpd, bit read_ok, logic [1:0] status);
        in_word_t w;
        w.action = act;
        w.hpd_level = hpd;
        w.edid_read_ok = read_ok;
        w.recheck_status = status;
        while (sender_gaps && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        expected_words.push_back(sequencer_step(w));
    endtask

    // sender holds off until every predicted word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [TICK_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_STABILIZE:    settings.stabilize_ticks = value;
            CFG_DROP_TIMEOUT: settings.drop_timeout_ticks = value;
            CFG_PLUG_CHECK:   settings.plug_check_ticks = value;
            CFG_EDID_RETRY:   settings.edid_retry_ticks = value;
            CFG_MAX_ATTEMPTS: settings.max_edid_attempts = value[ATTEMPT_W-1:0];
            default:          ;
        endcase
    endtask

    // registers only change with nothing in flight
    task automatic set_config(cfg_t c);
        wait_drained();
        write_reg(CFG_STABILIZE, c.stabilize_ticks);
        write_reg(CFG_DROP_TIMEOUT, c.drop_timeout_ticks);
        write_reg(CFG_PLUG_CHECK, c.plug_check_ticks);
        write_reg(CFG_EDID_RETRY, c.edid_retry_ticks);
        write_reg(CFG_MAX_ATTEMPTS, {{(TICK_W-ATTEMPT_W){1'b0}}, c.max_edid_attempts});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly short delays so the machine gets round its states often
    function automatic logic [TICK_W-1:0] random_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return TICK_W'($urandom_range(0, 4));
        else if (roll < 80)
            return TICK_W'($urandom_range(5, 30));
        else if (roll < 90)
            return $urandom_range(0, 1) ? '1 : '0;
        else
            return TICK_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [1:0] random_recheck();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return RECHECK_UNCHANGED;
        else if (roll < 75)
            return RECHECK_FAILED;
        else if (roll < 90)
            return RECHECK_CHANGED;
        else
            return RECHECK_UNKNOWN;
    endfunction

    // nothing armed after reset: a tick and the unused code just report boot
    task automatic test_idle_items();
        send_word(ACT_TICK, 1'b1, 1'b1, RECHECK_UNKNOWN);
        send_word(ACT_UNUSED, 1'b1, 1'b1, RECHECK_UNKNOWN);
        send_word(ACT_TICK, 1'b0, 1'b0, RECHECK_UNCHANGED);
    endtask

    // takeover, plug check, edid failures to give-up, restart, then a good read
    task automatic test_plug_and_read();
        set_config('{stabilize_ticks: 16'd1, drop_timeout_ticks: 16'd2,
                     plug_check_ticks: 16'd0, edid_retry_ticks: 16'd1,
                     max_edid_attempts: 3'd2});
        send_word(ACT_EVENT, 1'b0, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_EVENT, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b1, RECHECK_UNCHANGED);
    endtask

    // bounce while enabled, drop and reassert, failed, unchanged and unknown rechecks
    task automatic test_drop_and_recheck();
        send_word(ACT_EVENT, 1'b1, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_EVENT, 1'b0, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b0, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_EVENT, 1'b1, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b1, RECHECK_FAILED);
        send_word(ACT_TICK, 1'b1, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_EVENT, 1'b0, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b0, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_EVENT, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b0, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b0, RECHECK_UNKNOWN);
    endtask

    // hotplug sessions: events on line edges and bounces, ticks carrying the
    // line level, a little noise and the odd wait for the pipe to empty
    task automatic test_random_sessions(cfg_t c, bit quiet);
        int roll;
        bit hpd;
        set_config(c);
        sender_gaps = !quiet;
        receiver_stalls = !quiet;
        for (int k = 0; k < PHASE_WORDS; k++)
        begin
            roll = $urandom_range(0, 99);
            if (!quiet && $urandom_range(0, 99) == 0)
                wait_drained();
            if (roll < 10)
            begin
                if ($urandom_range(0, 1))
                    plug_line = ~plug_line;
                send_word(ACT_EVENT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          2'($urandom_range(0, 3)));
            end
            else if (roll < 13)
                send_word($urandom_range(0, 1) ? ACT_EVENT : ACT_UNUSED,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          2'($urandom_range(0, 3)));
            else
            begin
                hpd = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : plug_line;
                send_word(ACT_TICK, hpd, $urandom_range(0, 99) < 65, random_recheck());
            end
        end
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // shutdown cannot be undone, so it closes the run: afterwards events only
    // mark work pending and ticks find nothing armed
    task automatic test_shutdown();
        set_config('{stabilize_ticks: 16'd0, drop_timeout_ticks: 16'd0,
                     plug_check_ticks: 16'd0, edid_retry_ticks: 16'd0,
                     max_edid_attempts: 3'd1});
        send_word(ACT_EVENT, 1'b1, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_SHUTDOWN, 1'b1, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_TICK, 1'b1, 1'b1, RECHECK_UNCHANGED);
        send_word(ACT_EVENT, 1'b0, 1'b0, RECHECK_CHANGED);
        send_word(ACT_TICK, 1'b0, 1'b0, RECHECK_CHANGED);
        send_word(ACT_UNUSED, 1'b0, 1'b0, RECHECK_FAILED);
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        c.stabilize_ticks = random_delay();
        c.drop_timeout_ticks = random_delay();
        c.plug_check_ticks = random_delay();
        c.edid_retry_ticks = random_delay();
        c.max_edid_attempts = ATTEMPT_W'($urandom_range(0, 7));
        return c;
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_items();
        test_plug_and_read();
        test_drop_and_recheck();

        // random phases: register settings change between them, extremes included
        test_random_sessions(random_settings(), 1'b0);
        test_random_sessions('{stabilize_ticks: RST_STABILIZE,
                               drop_timeout_ticks: RST_DROP_TIMEOUT,
                               plug_check_ticks: RST_PLUG_CHECK,
                               edid_retry_ticks: RST_EDID_RETRY,
                               max_edid_attempts: RST_MAX_ATTEMPTS}, 1'b0);
        test_random_sessions('{stabilize_ticks: '0, drop_timeout_ticks: '0,
                               plug_check_ticks: '0, edid_retry_ticks: '0,
                               max_edid_attempts: '0}, 1'b0);
        test_random_sessions(random_settings(), 1'b1);   // no idling on either side
        test_random_sessions('{stabilize_ticks: '1, drop_timeout_ticks: '1,
                               plug_check_ticks: '1, edid_retry_ticks: '1,
                               max_edid_attempts: '1}, 1'b0);
        test_random_sessions(random_settings(), 1'b0);
        test_random_sessions(random_settings(), 1'b0);
        test_random_sessions(random_settings(), 1'b0);

        test_shutdown();

        wait_drained();
        repeat (4) @(posedge clk);

        $display("covered %0d words over %0d register settings; worker ran %0d times",
                 words_checked, settings_used, worker_runs);
        $display("states reached %b, disable pulses %0d, edid-ready pulses %0d",
                 state_mask, disable_seen, ready_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/hpd_seq_pkg.sv
hdl/hpd_seq_cfg.sv
hdl/hpd_seq_fsm.sv
hdl/hotplug_detect_sequencer.sv
verif/tb_hotplug_detect_sequencer.sv
